/* rtl/core/radio_escape_command_buffer_assert.svh */
// Assertion macros used by the command buffer top level.
`ifndef RADIO_ESCAPE_COMMAND_BUFFER_ASSERT_SVH
`define RADIO_ESCAPE_COMMAND_BUFFER_ASSERT_SVH

// Checks a consequence in the same cycle as its trigger.
`define RECB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks a consequence in the cycle after its trigger.
`define RECB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/recb_pkg.sv */
// Shared types and constants for the escape command buffer.
`timescale 1ns / 1ps
`default_nettype none

package recb_pkg;

   // Result kinds.
   localparam logic [1:0] KIND_PACKET  = 2'd0;
   localparam logic [1:0] KIND_VERSION = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   // Command characters seen after the escape.
   localparam logic [7:0] CH_BANG = 8'h21;
   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_C    = 8'h43;
   localparam logic [7:0] CH_Z    = 8'h5A;
   localparam logic [7:0] CH_V    = 8'h56;
   localparam logic [7:0] CH_F    = 8'h46;
   localparam logic [7:0] CH_H    = 8'h48;
   localparam logic [7:0] CH_L    = 8'h4C;
   localparam logic [7:0] CH_R    = 8'h52;

   // Reply characters.
   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_E    = 8'h45;

   // Packet and airtime constants.
   localparam logic [7:0]  MAX_PACKET   = 8'd255;
   localparam logic [8:0]  HEADER_BYTES = 9'd8;
   localparam int          DVD_W        = 22;
   localparam logic [21:0] AIR_SCALE    = 22'd8000;
   localparam logic [30:0] RATE_LIMIT   = 31'd999999999;
   localparam logic [11:0] AIRTIME_MAX  = 12'hFFF;
   localparam logic [30:0] BIT_RATE_RST = 31'd128000;

   // Status of the airtime divider as seen by the controller.
   typedef struct packed {
      logic        busy;
      logic [11:0] ms;
   } air_stat_type;

endpackage

`default_nettype wire

/* rtl/core/recb_byte_ram.sv */
// Byte store: one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module recb_byte_ram #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/recb_airtime.sv */
// Airtime unit: restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module recb_airtime (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [7:0]              pkt_len,
   input  wire logic [30:0]             bit_rate,
   output recb_pkg::air_stat_type       stat
);
   import recb_pkg::*;

   logic              busy_ff, busy_in;
   logic [4:0]        step_ff, step_in;
   logic              zero_ff, zero_in;
   logic [30:0]       dvs_ff, dvs_in;
   logic [31:0]       rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [31:0]       rem_sh;
   logic              ge;

   // One restoring step; the dividend register collects quotient bits.
   always_comb begin
      rem_sh  = {rem_ff[30:0], dvd_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      step_in = step_ff;
      zero_in = zero_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         // Milliseconds equal 8000 * (8 + n) / bit_rate, truncated.
         zero_in = bit_rate > RATE_LIMIT;
         busy_in = !(bit_rate > RATE_LIMIT);
         step_in = 5'(DVD_W - 1);
         dvs_in  = bit_rate;
         rem_in  = '0;
         dvd_in  = DVD_W'(({1'b0, pkt_len} + HEADER_BYTES)) * AIR_SCALE;
      end else if (busy_ff) begin
         rem_in  = ge ? rem_sh - {1'b0, dvs_ff} : rem_sh;
         dvd_in  = {dvd_ff[DVD_W-2:0], ge};
         step_in = step_ff - 5'd1;
         busy_in = step_ff != 5'd0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         zero_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         zero_ff <= zero_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
   end

   // Result, saturated to twelve bits.
   always_comb begin
      stat.busy = busy_ff;
      if (zero_ff) begin
         stat.ms = '0;
      end else if (|dvd_ff[DVD_W-1:12]) begin
         stat.ms = AIRTIME_MAX;
      end else begin
         stat.ms = dvd_ff[11:0];
      end
   end

endmodule

`default_nettype wire

/* rtl/core/radio_escape_command_buffer.sv */
// Top level of the escape command buffer: controller, byte store and CSR.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     rx_byte
//   rsp      out        rsp_valid/stall     kind, data_word, byte_count, last, airtime_ms
//   csr      in/out     APB psel/penable    bit_rate at offset 0
//
// An ordinary byte, a clear or a reply leaves the controller idle, so the next byte can be taken unless a result waits.
// A packet send of n bytes reads the bytes in order and gathers them into words of up to eight
// bytes: each byte is read from the store and placed in the word, each word is emitted once it
// is full or the packet ends, and the first word waits for the 22 steps of the divider.
// The input stalls while a packet is read out and while a result waits for a stalled rsp.
// Reset is synchronous and empties the buffer; no clearing pass over the store is run.
`timescale 1ns / 1ps
`default_nettype none

module radio_escape_command_buffer #(
   parameter int BUFFER_DEPTH = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [63:0]      rsp_data_word,
   output logic [3:0]       rsp_byte_count,
   output logic             rsp_last,
   output logic [11:0]      rsp_airtime_ms,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import recb_pkg::*;

   localparam int PTR_W = $clog2(BUFFER_DEPTH);
   localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_GATHER = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic             armed_ff, armed_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]       remain_ff, remain_in;
   logic             pend_ff, pend_in;
   logic [3:0]       wcnt_ff, wcnt_in;
   logic [63:0]      word_ff, word_in;
   logic [30:0]      bit_rate_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_kind_ff, rsp_kind_in;
   logic [63:0]      rsp_word_ff, rsp_word_in;
   logic [3:0]       rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;
   logic [11:0]      rsp_air_ff, rsp_air_in;

   logic             req_xfer;
   logic             slot_free;
   logic             push;
   logic [7:0]       push_byte;
   logic             wr_en;
   logic             rd_en;
   logic [7:0]       rd_data;
   logic             air_start;
   logic [7:0]       pkt_n;
   logic [PTR_W:0]   head_sum;
   logic [3:0]       wcnt_got;
   air_stat_type     air_stat;

   // Handshakes.
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !slot_free;
   assign req_xfer  = req_valid && !req_stall;

   // Packet length and the head pointer after it, wrapped once.
   assign pkt_n    = (fill_ff > CNT_W'(MAX_PACKET)) ? MAX_PACKET : fill_ff[7:0];
   assign head_sum = {1'b0, head_ff} + (PTR_W + 1)'(pkt_n);

   // Controller: command decode, FIFO pointers and packet read-out.
   always_comb begin
      state_in     = state_ff;
      armed_in     = armed_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      remain_in    = remain_ff;
      pend_in      = 1'b0;
      wcnt_in      = wcnt_ff;
      word_in      = word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_air_in   = rsp_air_ff;
      push         = 1'b0;
      push_byte    = req_rx_byte;
      rd_en        = 1'b0;
      air_start    = 1'b0;
      wcnt_got     = wcnt_ff + 4'(pend_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (!armed_ff) begin
                  if (req_rx_byte == CH_BANG) begin
                     armed_in = 1'b1;
                  end else begin
                     push = 1'b1;
                  end
               end else begin
                  armed_in = 1'b0;
                  unique case (req_rx_byte)
                     CH_BANG: begin
                        // Claim the packet now; no byte is taken until it is out.
                        air_start = 1'b1;
                        rd_ptr_in = head_ff;
                        remain_in = pkt_n;
                        wcnt_in   = '0;
                        word_in   = '0;
                        fill_in   = fill_ff - CNT_W'(pkt_n);
                        head_in   = (head_sum >= (PTR_W + 1)'(BUFFER_DEPTH))
                                    ? PTR_W'(head_sum - (PTR_W + 1)'(BUFFER_DEPTH))
                                    : head_sum[PTR_W-1:0];
                        state_in  = (pkt_n == 8'd0) ? ST_EMIT : ST_GATHER;
                     end
                     CH_C, CH_Z: begin
                        head_in = '0;
                        tail_in = '0;
                        fill_in = '0;
                     end
                     CH_DOT: begin
                        push      = 1'b1;
                        push_byte = CH_BANG;
                     end
                     CH_V: begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_VERSION;
                        rsp_word_in  = 64'(CH_ONE);
                        rsp_count_in = 4'd1;
                        rsp_last_in  = 1'b1;
                        rsp_air_in   = '0;
                     end
                     CH_F, CH_H, CH_L, CH_R: begin
                     end
                     default: begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_ERROR;
                        rsp_word_in  = 64'(CH_E);
                        rsp_count_in = 4'd1;
                        rsp_last_in  = 1'b1;
                        rsp_air_in   = '0;
                     end
                  endcase
               end
            end
         end
         ST_GATHER: begin
            // Place the byte read last cycle, then read on while the word holds fewer than eight bytes.
            if (pend_ff) begin
               word_in[wcnt_ff[2:0]*8 +: 8] = rd_data;
            end
            wcnt_in = wcnt_got;
            if ((remain_ff != 8'd0) && (wcnt_got < 4'd8)) begin
               rd_en     = 1'b1;
               pend_in   = 1'b1;
               remain_in = remain_ff - 8'd1;
               rd_ptr_in = (rd_ptr_ff == PTR_W'(BUFFER_DEPTH - 1)) ? '0
                           : rd_ptr_ff + 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // A word leaves once the airtime is known and the output is free.
            if (!air_stat.busy && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_PACKET;
               rsp_word_in  = word_ff;
               rsp_count_in = wcnt_ff;
               rsp_last_in  = remain_ff == 8'd0;
               rsp_air_in   = air_stat.ms;
               wcnt_in      = '0;
               word_in      = '0;
               state_in     = (remain_ff == 8'd0) ? ST_IDLE : ST_GATHER;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Append a byte at the tail unless the buffer is full.
      wr_en = push && (fill_ff < CNT_W'(BUFFER_DEPTH));
      if (wr_en) begin
         fill_in = fill_ff + 1'b1;
         tail_in = (tail_ff == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         armed_ff     <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         bit_rate_ff  <= BIT_RATE_RST;
      end else begin
         state_ff     <= state_in;
         armed_ff     <= armed_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
            bit_rate_ff <= csr_pwdata[30:0];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      remain_ff    <= remain_in;
      wcnt_ff      <= wcnt_in;
      word_ff      <= word_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_air_ff   <= rsp_air_in;
   end

   // Byte store.
   recb_byte_ram #(
      .DEPTH  (BUFFER_DEPTH),
      .ADDR_W (PTR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (push_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Airtime divider.
   recb_airtime u_air (
      .clock    (clock),
      .reset    (reset),
      .start    (air_start),
      .pkt_len  (pkt_n),
      .bit_rate (bit_rate_ff),
      .stat     (air_stat)
   );

   // Output and register read ports.
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_data_word  = rsp_word_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_airtime_ms = rsp_air_ff;
   assign csr_pready     = 1'b1;
   assign csr_prdata     = csr_paddr[2] ? 32'd0 : {1'b0, bit_rate_ff};

   `include "radio_escape_command_buffer_assert.svh"

   `RECB_ASSERT_SAME(a_fill_bound, 1'b1, fill_ff <= CNT_W'(BUFFER_DEPTH),
      "fill count exceeds buffer depth")
   `RECB_ASSERT_SAME(a_busy_stall, state_ff != ST_IDLE, req_stall,
      "input accepted during packet read-out")
   `RECB_ASSERT_SAME(a_reply_shape, rsp_valid && (rsp_kind != KIND_PACKET),
      (rsp_byte_count == 4'd1) && rsp_last && (rsp_airtime_ms == 12'd0),
      "malformed reply result")
   `RECB_ASSERT_NEXT(a_read_lands, rd_en, pend_ff && (state_ff == ST_GATHER),
      "store read issued without gather cycle to take it")

endmodule

`default_nettype wire
